// ===== design/fpa_pkg.sv =====
// shared types and constants for the q24.8 fixed-point alu
// no dependencies
package fpa_pkg;

   localparam int OPCODE_WIDTH = 4;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_LE       = 4'd6,
      OP_GE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } opcode_type;

endpackage

// ===== design/fpa_if.sv =====
// valid/ready channel interfaces for alu requests and responses
// depends on fpa_pkg
interface fpa_req_if #(parameter int DATA_WIDTH = 32);
   logic                               valid;
   logic                               ready;
   logic [fpa_pkg::OPCODE_WIDTH-1:0]   opcode;
   logic signed [DATA_WIDTH-1:0]       operand_a;
   logic signed [DATA_WIDTH-1:0]       operand_b;

   modport source (output valid, opcode, operand_a, operand_b, input ready);
   modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result_value;
   logic                         compare_true;
   logic                         divide_by_zero;

   modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
   modport sink   (input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface

// ===== design/fpa_div_step.sv =====
// one restoring division step: one quotient bit per stage
// no package dependencies
module fpa_div_step #(
   parameter int DATA_WIDTH = 32,
   parameter int NUM_WIDTH  = 40
) (
   input  logic [DATA_WIDTH-1:0] rem_in,
   input  logic [NUM_WIDTH-1:0]  num_in,
   input  logic [DATA_WIDTH-1:0] den_in,
   output logic [DATA_WIDTH-1:0] rem_out,
   output logic [NUM_WIDTH-1:0]  num_out
);
   logic [DATA_WIDTH:0] trial;
   logic [DATA_WIDTH:0] diff;
   logic                fits;

   // shift next dividend bit in, subtract if divisor fits
   always_comb begin
      trial   = {rem_in, num_in[NUM_WIDTH-1]};
      diff    = trial - {1'b0, den_in};
      fits    = trial >= {1'b0, den_in};
      rem_out = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      num_out = {num_in[NUM_WIDTH-2:0], fits};
   end
endmodule

// ===== design/fixed_point_q24_8_alu_unit.sv =====
// top level of the signed fixed-point alu, fully pipelined
// depends on fpa_pkg, fpa_if and fpa_div_step
//
// usage:
//  req_chan carries opcode, operand_a and operand_b; rsp_chan returns
//  result_value, compare_true and divide_by_zero, one response per request,
//  in request order.
//  every operation flows through the same pipeline: an input register, a
//  prepare stage (multiplier, compares and operand magnitudes), one restoring
//  division stage per quotient bit (DATA_WIDTH + FRAC_BITS of them) and an
//  output register. throughput is one transaction per cycle unless the
//  receiver stalls; the divider sets the depth.
//  when the receiver stalls with a response waiting, the whole pipeline
//  holds and req_chan.ready drops; nothing is lost or repeated.
//  synchronous reset clears all stage valid bits and holds req_chan.ready
//  low; the block then accepts at once.
module fixed_point_q24_8_alu_unit #(
   parameter int FRAC_BITS  = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   fpa_req_if.sink  req_chan,
   fpa_rsp_if.source rsp_chan
);
   import fpa_pkg::*;

   localparam int NUM_WIDTH = DATA_WIDTH + FRAC_BITS;
   localparam int DIV_LAST  = NUM_WIDTH + 1;
   localparam int LAST      = NUM_WIDTH + 2;

   logic advance;

   // stage valids
   logic vld_ff [0:LAST];

   // input stage
   logic [OPCODE_WIDTH-1:0]       op_ff;
   logic signed [DATA_WIDTH-1:0]  a_ff;
   logic signed [DATA_WIDTH-1:0]  b_ff;

   // carried payload
   logic [DATA_WIDTH-1:0] res_ff   [1:LAST];
   logic                  cmp_ff   [1:LAST];
   logic                  dz_ff    [1:LAST];
   logic                  isdiv_ff [1:DIV_LAST];
   logic                  qneg_ff  [1:DIV_LAST];
   logic [DATA_WIDTH-1:0] rem_ff   [1:DIV_LAST];
   logic [NUM_WIDTH-1:0]  num_ff   [1:DIV_LAST];
   logic [DATA_WIDTH-1:0] den_ff   [1:DIV_LAST];

   // prepare stage next values
   logic [DATA_WIDTH-1:0]   res_in;
   logic                    cmp_in;
   logic                    dz_in;
   logic                    isdiv_in;
   logic [2*DATA_WIDTH-1:0] prod;
   logic [DATA_WIDTH-1:0]   abs_a;
   logic [DATA_WIDTH-1:0]   abs_b;
   logic                    a_lt_b;
   logic                    b_lt_a;

   // divider step outputs
   logic [DATA_WIDTH-1:0] step_rem [2:DIV_LAST];
   logic [NUM_WIDTH-1:0]  step_num [2:DIV_LAST];

   // final quotient
   logic [DATA_WIDTH-1:0] quo;
   logic [DATA_WIDTH-1:0] res_out_in;

   // whole pipeline moves unless a response is stuck
   assign advance        = !vld_ff[LAST] || rsp_chan.ready;
   assign req_chan.ready = advance && !reset;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_chan.valid;
         for (int i = 1; i <= LAST; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff <= req_chan.opcode;
         a_ff  <= req_chan.operand_a;
         b_ff  <= req_chan.operand_b;
      end
   end

   // prepare: multiply, compares and non-divide results
   always_comb begin
      prod     = $signed({{DATA_WIDTH{a_ff[DATA_WIDTH-1]}}, a_ff})
                 * $signed({{DATA_WIDTH{b_ff[DATA_WIDTH-1]}}, b_ff});
      abs_a    = a_ff[DATA_WIDTH-1] ? (~a_ff + 1'b1) : a_ff;
      abs_b    = b_ff[DATA_WIDTH-1] ? (~b_ff + 1'b1) : b_ff;
      a_lt_b   = a_ff < b_ff;
      b_lt_a   = b_ff < a_ff;
      res_in   = '0;
      cmp_in   = 1'b0;
      dz_in    = 1'b0;
      isdiv_in = 1'b0;
      case (opcode_type'(op_ff))
         OP_ADD:      res_in = a_ff + b_ff;
         OP_SUB:      res_in = a_ff - b_ff;
         OP_MUL:      res_in = prod[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
         OP_DIV: begin
            if (b_ff == '0) dz_in = 1'b1;
            else isdiv_in = 1'b1;
         end
         OP_GT:       cmp_in = b_lt_a;
         OP_LT:       cmp_in = a_lt_b;
         OP_LE:       cmp_in = !b_lt_a;
         OP_GE:       cmp_in = !a_lt_b;
         OP_EQ:       cmp_in = a_ff == b_ff;
         OP_NE:       cmp_in = a_ff != b_ff;
         OP_MIN:      res_in = a_lt_b ? a_ff : b_ff;
         OP_MAX:      res_in = b_lt_a ? a_ff : b_ff;
         OP_INC:      res_in = a_ff + 1'b1;
         OP_DEC:      res_in = a_ff - 1'b1;
         OP_FROM_INT: res_in = a_ff << FRAC_BITS;
         OP_TO_INT:   res_in = a_ff >>> FRAC_BITS;
         default:     res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff[1]   <= res_in;
         cmp_ff[1]   <= cmp_in;
         dz_ff[1]    <= dz_in;
         isdiv_ff[1] <= isdiv_in;
         qneg_ff[1]  <= a_ff[DATA_WIDTH-1] ^ b_ff[DATA_WIDTH-1];
         rem_ff[1]   <= '0;
         num_ff[1]   <= {abs_a, {FRAC_BITS{1'b0}}};
         den_ff[1]   <= abs_b;
      end
   end

   // division stages, one quotient bit each
   for (genvar g = 2; g <= DIV_LAST; g++) begin : g_div
      fpa_div_step #(
         .DATA_WIDTH (DATA_WIDTH),
         .NUM_WIDTH  (NUM_WIDTH)
      ) u_step (
         .rem_in  (rem_ff[g-1]),
         .num_in  (num_ff[g-1]),
         .den_in  (den_ff[g-1]),
         .rem_out (step_rem[g]),
         .num_out (step_num[g])
      );

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[g]   <= step_rem[g];
            num_ff[g]   <= step_num[g];
            den_ff[g]   <= den_ff[g-1];
            res_ff[g]   <= res_ff[g-1];
            cmp_ff[g]   <= cmp_ff[g-1];
            dz_ff[g]    <= dz_ff[g-1];
            isdiv_ff[g] <= isdiv_ff[g-1];
            qneg_ff[g]  <= qneg_ff[g-1];
         end
      end
   end

   // sign fix of quotient and final select
   always_comb begin
      quo        = num_ff[DIV_LAST][DATA_WIDTH-1:0];
      res_out_in = isdiv_ff[DIV_LAST] ? (qneg_ff[DIV_LAST] ? (~quo + 1'b1) : quo)
                                      : res_ff[DIV_LAST];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff[LAST] <= res_out_in;
         cmp_ff[LAST] <= cmp_ff[DIV_LAST];
         dz_ff[LAST]  <= dz_ff[DIV_LAST];
      end
   end

   assign rsp_chan.valid          = vld_ff[LAST];
   assign rsp_chan.result_value   = res_ff[LAST];
   assign rsp_chan.compare_true   = cmp_ff[LAST];
   assign rsp_chan.divide_by_zero = dz_ff[LAST];

`ifndef ASSERT_OFF
   // divide by zero never raises a compare flag or a value
   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] && dz_ff[LAST] |-> !cmp_ff[LAST] && res_ff[LAST] == '0)
      else $error("divide by zero response carries data");

   // a real divide is never also flagged as divide by zero
   a_div_excl: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_LAST] && isdiv_ff[DIV_LAST] |-> !dz_ff[DIV_LAST])
      else $error("divide and divide by zero both set");

   // an item in the input stage moves to prepare when the pipe advances
   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      advance && vld_ff[0] |=> vld_ff[1])
      else $error("transaction lost between input and prepare stage");

   // stored remainder stays below divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_LAST] && isdiv_ff[DIV_LAST] |-> rem_ff[DIV_LAST] < den_ff[DIV_LAST])
      else $error("division remainder out of range");
`endif
endmodule

// ===== test/fpa_alu_checker.sv =====
// response checker for the q24.8 fixed-point alu
// depends on fpa_pkg and fpa_if; predicts each response and compares in order
`timescale 1ns / 1ps

module fpa_alu_checker (
   input  logic     clock,
   input  logic     reset,
   fpa_req_if       req_chan,
   fpa_rsp_if       rsp_chan,
   output int       error_count,
   output int       pending_count
);
   import fpa_pkg::*;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               compare_true;
      logic               divide_by_zero;
   } alu_answer_type;

   alu_answer_type answer_queue[$];

   // compute the expected answer for one request
   function automatic alu_answer_type compute_answer(logic [3:0] op, logic signed [31:0] a,
                                                     logic signed [31:0] b);
      alu_answer_type ans;
      logic signed [63:0] prod;
      logic signed [63:0] quot;
      logic signed [63:0] dividend;
      ans = '0;
      case (opcode_type'(op))
         OP_ADD:      ans.result_value = a + b;
         OP_SUB:      ans.result_value = a - b;
         OP_MUL: begin
            prod = 64'(a) * 64'(b);
            ans.result_value = prod[39:8];
         end
         OP_DIV: begin
            if (b == 0) begin
               ans.divide_by_zero = 1'b1;
            end else begin
               dividend = 64'(a) <<< 8;
               quot = dividend / 64'(b);
               ans.result_value = quot[31:0];
            end
         end
         OP_GT:       ans.compare_true = a > b;
         OP_LT:       ans.compare_true = a < b;
         OP_LE:       ans.compare_true = a <= b;
         OP_GE:       ans.compare_true = a >= b;
         OP_EQ:       ans.compare_true = a == b;
         OP_NE:       ans.compare_true = a != b;
         OP_MIN:      ans.result_value = (a < b) ? a : b;
         OP_MAX:      ans.result_value = (b < a) ? a : b;
         OP_INC:      ans.result_value = a + 32'sd1;
         OP_DEC:      ans.result_value = a - 32'sd1;
         OP_FROM_INT: ans.result_value = a <<< 8;
         default:     ans.result_value = a >>> 8;
      endcase
      return ans;
   endfunction

   assign pending_count = answer_queue.size();

   // record requests and compare responses at each edge
   always @(posedge clock) begin
      alu_answer_type want;
      int             mismatches;
      mismatches = 0;
      if (reset) begin
         error_count <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            answer_queue.push_back(compute_answer(req_chan.opcode, req_chan.operand_a,
                                                  req_chan.operand_b));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (answer_queue.size() == 0) begin
               $error("unexpected response transaction");
               mismatches++;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_chan.result_value !== want.result_value) begin
                  $error("result_value expected %0d actual %0d", want.result_value,
                         rsp_chan.result_value);
                  mismatches++;
               end
               if (rsp_chan.compare_true !== want.compare_true) begin
                  $error("compare_true expected %0b actual %0b", want.compare_true,
                         rsp_chan.compare_true);
                  mismatches++;
               end
               if (rsp_chan.divide_by_zero !== want.divide_by_zero) begin
                  $error("divide_by_zero expected %0b actual %0b", want.divide_by_zero,
                         rsp_chan.divide_by_zero);
                  mismatches++;
               end
            end
         end
         error_count <= error_count + mismatches;
      end
   end
endmodule

// ===== test/fixed_point_q24_8_alu_unit_tb.sv =====
// top-level testbench for the q24.8 fixed-point alu
// depends on fpa_pkg, fpa_if, fpa_alu_checker and the alu top level
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_unit_tb;
   import fpa_pkg::*;

   localparam int RANDOM_ITEMS = 1730;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   pending_count;
   int   idle_cycles = 0;
   int   send_idle_pct = 26;
   int   recv_idle_pct = 70;

   fpa_req_if #(.DATA_WIDTH(32)) req_chan ();
   fpa_rsp_if #(.DATA_WIDTH(32)) rsp_chan ();

   fixed_point_q24_8_alu_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   fpa_alu_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #6 clock = ~clock;

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // operand drawn with a bias toward edge values
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(signed'($urandom_range(512))) - 32'd256;
         3: return 32'd0;
         4: return 32'($urandom_range(65535)) ^ {32{$urandom_range(1) == 1}};
         default: return $urandom;
      endcase
   endfunction

   // drive one request and hold it until accepted
   task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.opcode    <= op;
      req_chan.operand_a <= a;
      req_chan.operand_b <= b;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   initial begin
      int phase;
      req_chan.valid     = 1'b0;
      req_chan.opcode    = '0;
      req_chan.operand_a = '0;
      req_chan.operand_b = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every operation plus edge cases
      for (int op = 0; op < 16; op++)
         send_request(op[3:0], 32'h0000_0380, 32'hffff_fe80);
      send_request(OP_DIV, 32'h0000_1000, 32'd0);
      send_request(OP_DIV, 32'h8000_0000, 32'hffff_ff00);
      send_request(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
      send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000);
      send_request(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
      send_request(OP_INC, 32'h7fff_ffff, 32'h0);
      send_request(OP_DEC, 32'h8000_0000, 32'h0);
      send_request(OP_MIN, 32'h0000_0100, 32'h0000_0100);
      send_request(OP_TO_INT, 32'hffff_ff01, 32'h0);

      // random traffic in three idling phases
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 70 : 0;
         recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 26 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            send_request(4'($urandom_range(15)), pick_operand(), pick_operand());
      end
      req_chan.valid <= 1'b0;

      // drain outstanding responses
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
